// ===== rtl/core/vpa_pkg.sv =====
// Package for the variable partition allocator.
// Holds sizes, status, policy and cell-op codes, and the partition entry type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vpa_pkg;
  localparam int MEM_UNITS  = 1024;
  localparam int MAX_PARTS  = 16;
  localparam int OWNER_BITS = 8;
  localparam int ADDR_W     = $clog2(MEM_UNITS);
  localparam int SIZE_W     = $clog2(MEM_UNITS + 1);
  localparam int IDX_W      = $clog2(MAX_PARTS);
  localparam int CNT_W      = $clog2(MAX_PARTS + 1);

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NOOWNER = 2'd3;

  // fit policies
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_NEXT  = 2'd1;
  localparam logic [1:0] POL_BEST  = 2'd2;
  localparam logic [1:0] POL_WORST = 2'd3;

  // transaction modes
  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef logic [1:0] cell_op_t;
  localparam cell_op_t OP_HOLD = 2'd0;
  localparam cell_op_t OP_UP   = 2'd1; // take the lower neighbor's entry
  localparam cell_op_t OP_DOWN = 2'd2; // take the upper neighbor's entry
  localparam cell_op_t OP_SET  = 2'd3; // take the broadcast write entry

  typedef struct packed {
    logic [ADDR_W-1:0]     start;
    logic [SIZE_W-1:0]     size;
    logic                  busy;
    logic [OWNER_BITS-1:0] owner;
  } entry_t;
endpackage
`default_nettype wire

// ===== rtl/core/vpa_req_if.sv =====
// Request and response channel interfaces for the partition allocator.
// Depends on vpa_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface vpa_req_if;
  logic                            valid;
  logic                            ready;
  logic                            mode;
  logic [vpa_pkg::OWNER_BITS-1:0]  owner_id;
  logic [vpa_pkg::SIZE_W-1:0]      request_size;
  modport source (output valid, mode, owner_id, request_size, input ready);
  modport sink   (input valid, mode, owner_id, request_size, output ready);
endinterface

interface vpa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [vpa_pkg::ADDR_W-1:0]  block_start;
  logic [vpa_pkg::SIZE_W-1:0]  block_size;
  modport source (output valid, status, block_start, block_size, input ready);
  modport sink   (input valid, status, block_start, block_size, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/vpa_cell.sv =====
// One partition table cell: holds one entry and loads from a neighbor or a write.
// Depends on vpa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vpa_cell (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire vpa_pkg::entry_t  rst_val,
  input  wire vpa_pkg::cell_op_t op,
  input  wire vpa_pkg::entry_t  lower,
  input  wire vpa_pkg::entry_t  upper,
  input  wire vpa_pkg::entry_t  wdata,
  output vpa_pkg::entry_t       ent
);
  vpa_pkg::entry_t ent_next;

  // neighbor / write select
  always_comb begin
    case (op)
      vpa_pkg::OP_UP:   ent_next = lower;
      vpa_pkg::OP_DOWN: ent_next = upper;
      vpa_pkg::OP_SET:  ent_next = wdata;
      default:          ent_next = ent;
    endcase
  end

  // busy, start and size reset; owner is undefined until written
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.start <= rst_val.start;
      ent.size  <= rst_val.size;
      ent.busy  <= 1'b0;
    end else begin
      ent.start <= ent_next.start;
      ent.size  <= ent_next.size;
      ent.busy  <= ent_next.busy;
    end
    ent.owner <= ent_next.owner;
  end
endmodule
`default_nettype wire

// ===== rtl/core/vpa_ctrl.sv =====
// Sequencer: scans the cell row, picks a partition, drives split/merge shifts.
// Depends on vpa_pkg and the channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
module vpa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_wdata,
  vpa_req_if.sink            req,
  vpa_rsp_if.source          rsp,
  input  wire vpa_pkg::entry_t ents [vpa_pkg::MAX_PARTS],
  output vpa_pkg::cell_op_t  ops  [vpa_pkg::MAX_PARTS],
  output vpa_pkg::entry_t    wdata
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FIND   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_SHIFT  = 4'd4;
  localparam logic [3:0] S_SETHI  = 4'd5;
  localparam logic [3:0] S_SETLO  = 4'd6;
  localparam logic [3:0] S_REL    = 4'd7;
  localparam logic [3:0] S_MERGER = 4'd8;
  localparam logic [3:0] S_MERGEL = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  localparam int IW = vpa_pkg::IDX_W;
  localparam int CW = vpa_pkg::CNT_W;

  logic [3:0]                     state;
  logic [1:0]                     fit_policy;
  logic [CW-1:0]                  count;
  logic [vpa_pkg::ADDR_W-1:0]     rover_addr;
  logic                           mode;
  logic [vpa_pkg::OWNER_BITS-1:0] owner;
  logic [vpa_pkg::SIZE_W-1:0]     req_size;
  logic [IW-1:0]                  idx;
  logic [CW-1:0]                  n;
  logic                           found;
  logic [IW-1:0]                  pick;
  logic [vpa_pkg::SIZE_W-1:0]     psize;
  logic [1:0]                     res_status;
  logic [vpa_pkg::ADDR_W-1:0]     res_start;
  logic [vpa_pkg::SIZE_W-1:0]     res_size;

  vpa_pkg::entry_t             cur, pk, up1, dn1;
  logic                        last_idx, fit, better, has_up, has_dn;
  logic                        rsp_load;
  logic [vpa_pkg::SIZE_W:0]    rover_sum;

  // cell reads
  assign cur      = ents[idx];
  assign pk       = ents[pick];
  assign up1      = ents[pick + IW'(1)];
  assign dn1      = ents[pick - IW'(1)];
  assign last_idx = ({1'b0, idx} == count - CW'(1));
  assign fit      = !cur.busy && (cur.size >= req_size);
  assign better   = !found ||
                    (fit_policy == vpa_pkg::POL_BEST  && cur.size < psize) ||
                    (fit_policy == vpa_pkg::POL_WORST && cur.size > psize);
  assign has_up   = ({1'b0, pick} + CW'(1) < count) && !up1.busy;
  assign has_dn   = (pick != '0) && !dn1.busy;
  assign rover_sum = {2'b0, res_start} + {1'b0, req_size};
  // response register takes a new result when empty or draining
  assign rsp_load = (state == S_DONE) && (!rsp.valid || rsp.ready);

  assign req.ready = (state == S_IDLE);

  // per-cell ops and broadcast write entry
  always_comb begin
    for (int j = 0; j < vpa_pkg::MAX_PARTS; j++) ops[j] = vpa_pkg::OP_HOLD;
    wdata = pk;
    case (state)
      S_SHIFT: begin
        for (int j = 0; j < vpa_pkg::MAX_PARTS; j++)
          if (IW'(j) > pick) ops[j] = vpa_pkg::OP_UP;
      end
      S_SETHI: begin
        wdata.start = res_start + req_size[vpa_pkg::ADDR_W-1:0];
        wdata.size  = psize - req_size;
        wdata.busy  = 1'b0;
        ops[pick + IW'(1)] = vpa_pkg::OP_SET;
      end
      S_SETLO: begin
        wdata.start = res_start;
        wdata.size  = req_size;
        wdata.busy  = 1'b1;
        wdata.owner = owner;
        ops[pick] = vpa_pkg::OP_SET;
      end
      S_REL: begin
        wdata.busy = 1'b0;
        ops[pick] = vpa_pkg::OP_SET;
      end
      S_MERGER: begin
        if (has_up) begin
          wdata.size = pk.size + up1.size;
          ops[pick] = vpa_pkg::OP_SET;
          for (int j = 0; j < vpa_pkg::MAX_PARTS; j++)
            if (IW'(j) > pick) ops[j] = vpa_pkg::OP_DOWN;
        end
      end
      S_MERGEL: begin
        if (has_dn) begin
          wdata      = dn1;
          wdata.size = dn1.size + pk.size;
          ops[pick - IW'(1)] = vpa_pkg::OP_SET;
          for (int j = 0; j < vpa_pkg::MAX_PARTS; j++)
            if (IW'(j) >= pick) ops[j] = vpa_pkg::OP_DOWN;
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fit_policy <= vpa_pkg::POL_FIRST;
      count      <= CW'(1);
      rover_addr <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      if (cfg_we) fit_policy <= cfg_wdata;
      if (rsp_load) rsp.valid <= 1'b1;
      else if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            mode     <= req.mode;
            owner    <= req.owner_id;
            req_size <= req.request_size;
            idx      <= '0;
            n        <= '0;
            found    <= 1'b0;
            res_status <= vpa_pkg::ST_OK;
            res_start  <= '0;
            res_size   <= '0;
            if (req.mode == vpa_pkg::MODE_RELEASE) state <= S_SCAN;
            else if (req.request_size == '0) begin
              res_status <= vpa_pkg::ST_NOFIT;
              state      <= S_DONE;
            end else if (fit_policy == vpa_pkg::POL_NEXT) state <= S_FIND;
            else state <= S_SCAN;
          end
        end
        // next fit: first partition at or above the rover
        S_FIND: begin
          if (cur.start >= rover_addr) state <= S_SCAN;
          else if (last_idx) begin
            idx   <= '0;
            state <= S_SCAN;
          end else idx <= idx + IW'(1);
        end
        S_SCAN: begin
          idx <= last_idx ? '0 : idx + IW'(1);
          n   <= n + CW'(1);
          if (mode == vpa_pkg::MODE_RELEASE) begin
            if (cur.busy && cur.owner == owner) begin
              pick  <= idx;
              state <= S_REL;
            end else if (n == count - CW'(1)) begin
              res_status <= vpa_pkg::ST_NOOWNER;
              state      <= S_DONE;
            end
          end else begin
            if (fit && better) begin
              found <= 1'b1;
              pick  <= idx;
              psize <= cur.size;
            end
            if ((fit && (fit_policy == vpa_pkg::POL_FIRST ||
                         fit_policy == vpa_pkg::POL_NEXT)) ||
                n == count - CW'(1))
              state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (!found) begin
            res_status <= vpa_pkg::ST_NOFIT;
            state      <= S_DONE;
          end else if (psize > req_size) begin
            if (count == CW'(vpa_pkg::MAX_PARTS)) begin
              res_status <= vpa_pkg::ST_FULL;
              state      <= S_DONE;
            end else begin
              res_start <= pk.start;
              state     <= S_SHIFT;
            end
          end else begin
            res_start <= pk.start;
            state     <= S_SETLO;
          end
        end
        S_SHIFT: begin
          count <= count + CW'(1);
          state <= S_SETHI;
        end
        S_SETHI: state <= S_SETLO;
        S_SETLO: begin
          res_size <= req_size;
          if (fit_policy == vpa_pkg::POL_NEXT)
            rover_addr <= (rover_sum >= (vpa_pkg::SIZE_W+1)'(vpa_pkg::MEM_UNITS)) ?
                          '0 : rover_sum[vpa_pkg::ADDR_W-1:0];
          state <= S_DONE;
        end
        S_REL: begin
          res_start <= pk.start;
          res_size  <= pk.size;
          state     <= S_MERGER;
        end
        S_MERGER: begin
          if (has_up) count <= count - CW'(1);
          state <= S_MERGEL;
        end
        S_MERGEL: begin
          if (has_dn) count <= count - CW'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            rsp.status      <= res_status;
            rsp.block_start <= (res_status == vpa_pkg::ST_OK) ? res_start : '0;
            rsp.block_size  <= (res_status == vpa_pkg::ST_OK) ? res_size  : '0;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // table never empty nor over capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != '0 && count <= CW'(vpa_pkg::MAX_PARTS))
    else $error("partition count out of range");
  // a split shift always adds one partition
  a_shift_grows: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |=> count == $past(count) + CW'(1))
    else $error("split did not grow the table");
  // the first partition always starts at address zero
  a_first_start: assert property (@(posedge clk) disable iff (rst)
    ents[0].start == '0)
    else $error("first partition moved");
  // a split is only started with room in the table
  a_split_room: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> count < CW'(vpa_pkg::MAX_PARTS))
    else $error("split with full table");
endmodule
`default_nettype wire

// ===== rtl/core/variable_partition_allocator_top.sv =====
// Variable partition allocator top: cell row plus sequencer.
// Depends on vpa_pkg, vpa_req_if/vpa_rsp_if, vpa_cell and vpa_ctrl.
//
//   channel   dir  payload                              handshake
//   req       in   mode, owner_id, request_size         valid/ready
//   rsp       out  status, block_start, block_size      valid/ready
//   cfg       in   fit_policy (cfg_wdata)               cfg_we
//
// One transaction at a time; req.ready is high only while idle. An allocation
// scans up to count entries, then decides, writes on success and loads the
// response. A split adds a shift and a remainder write; next fit first
// searches for the rover over up to count entries. A release frees the
// entry, then merges it with a free upper and then a free lower neighbor.
// Synchronous reset leaves one free partition covering all memory.
// The response register lets a new request enter while a result waits; a
// second result then holds the sequencer and stalls the input.
`timescale 1ns / 1ps
`default_nettype none
module variable_partition_allocator_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata,
  vpa_req_if.sink         req,
  vpa_rsp_if.source       rsp
);
  vpa_pkg::entry_t   ents [vpa_pkg::MAX_PARTS];
  vpa_pkg::cell_op_t ops  [vpa_pkg::MAX_PARTS];
  vpa_pkg::entry_t   wdata;

  vpa_ctrl u_ctrl (
    .clk, .rst, .cfg_we, .cfg_wdata, .req, .rsp,
    .ents, .ops, .wdata
  );

  // row of cells, each linked to its neighbors
  for (genvar g = 0; g < vpa_pkg::MAX_PARTS; g++) begin : g_cell
    vpa_pkg::entry_t rv, lo, hi;
    always_comb begin
      rv       = ents[g];
      rv.start = '0;
      rv.size  = (g == 0) ? vpa_pkg::SIZE_W'(vpa_pkg::MEM_UNITS) : '0;
      rv.busy  = 1'b0;
    end
    assign lo = (g == 0) ? ents[g] : ents[(g == 0) ? 0 : g - 1];
    assign hi = (g == vpa_pkg::MAX_PARTS - 1) ? ents[g]
              : ents[(g == vpa_pkg::MAX_PARTS - 1) ? g : g + 1];
    vpa_cell u_cell (
      .clk, .rst, .rst_val(rv), .op(ops[g]), .lower(lo), .upper(hi),
      .wdata, .ent(ents[g])
    );
  end
endmodule
`default_nettype wire

// ===== tb/sv/tb_variable_partition_allocator_top.sv =====
// Self-checking testbench for the variable partition allocator top.
// Depends on vpa_pkg, vpa_req_if/vpa_rsp_if and the allocator RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_variable_partition_allocator_top;

  typedef struct {
    logic [1:0]                 status;
    logic [vpa_pkg::ADDR_W-1:0] bstart;
    logic [vpa_pkg::SIZE_W-1:0] bsize;
  } grant_t;

  // Partition table model plus queue of predicted grants/releases
  class alloc_scoreboard;
    int          pstart[vpa_pkg::MAX_PARTS];
    int          psize[vpa_pkg::MAX_PARTS];
    bit          pbusy[vpa_pkg::MAX_PARTS];
    int          powner[vpa_pkg::MAX_PARTS];
    int          count;
    int          rover;
    logic [1:0]  policy;
    grant_t      grants_q[$];
    int          errors;
    int          mismatches;

    function new();
      count = 1;
      pstart[0] = 0;
      psize[0] = vpa_pkg::MEM_UNITS;
      foreach (pbusy[i]) pbusy[i] = 0;
      rover = 0;
      policy = vpa_pkg::POL_FIRST;
    endfunction

    function void move_entry(int dst, int src);
      pstart[dst] = pstart[src];
      psize[dst]  = psize[src];
      pbusy[dst]  = pbusy[src];
      powner[dst] = powner[src];
    endfunction

    function void drop_entry(int k);
      for (int j = k; j + 1 < count; j++) move_entry(j, j + 1);
      count--;
    endfunction

    function bit can_hold(int k, int req);
      return !pbusy[k] && psize[k] >= req;
    endfunction

    // index of the partition picked by the policy, count if none
    function int pick_partition(int req);
      int pick;
      int first;
      int k;
      pick = count;
      if (policy == vpa_pkg::POL_NEXT) begin
        first = 0;
        for (int i = 0; i < count; i++)
          if (pstart[i] >= rover) begin
            first = i;
            break;
          end
        for (int n = 0; n < count; n++) begin
          k = (first + n) % count;
          if (can_hold(k, req)) return k;
        end
        return count;
      end
      for (int i = 0; i < count; i++) begin
        if (!can_hold(i, req)) continue;
        if (policy == vpa_pkg::POL_FIRST) return i;
        if (pick == count ||
            (policy == vpa_pkg::POL_BEST && psize[i] < psize[pick]) ||
            (policy == vpa_pkg::POL_WORST && psize[i] > psize[pick]))
          pick = i;
      end
      return pick;
    endfunction

    // accepted request transaction: update table, queue the expected response
    function void note(logic m, logic [vpa_pkg::OWNER_BITS-1:0] own,
                       logic [vpa_pkg::SIZE_W-1:0] rsz);
      grant_t g;
      int     k;
      int     req;
      req = rsz;
      g.status = vpa_pkg::ST_OK;
      g.bstart = '0;
      g.bsize = '0;
      if (m == vpa_pkg::MODE_ALLOC) begin
        k = (req == 0) ? count : pick_partition(req);
        if (k >= count) g.status = vpa_pkg::ST_NOFIT;
        else if (psize[k] > req && count >= vpa_pkg::MAX_PARTS) g.status = vpa_pkg::ST_FULL;
        else begin
          g.bstart = vpa_pkg::ADDR_W'(pstart[k]);
          g.bsize = vpa_pkg::SIZE_W'(req);
          if (psize[k] > req) begin
            for (int j = count; j > k; j--) move_entry(j, j - 1);
            count++;
            pstart[k + 1] = pstart[k] + req;
            psize[k + 1] = psize[k + 1] - req;
            pbusy[k + 1] = 0;
          end
          psize[k] = req;
          pbusy[k] = 1;
          powner[k] = own;
          if (policy == vpa_pkg::POL_NEXT) begin
            rover = pstart[k] + req;
            if (rover >= vpa_pkg::MEM_UNITS) rover = 0;
          end
        end
      end else begin
        for (k = 0; k < count; k++)
          if (pbusy[k] && powner[k] == own) break;
        if (k == count) g.status = vpa_pkg::ST_NOOWNER;
        else begin
          g.bstart = vpa_pkg::ADDR_W'(pstart[k]);
          g.bsize = vpa_pkg::SIZE_W'(psize[k]);
          pbusy[k] = 0;
          if (k + 1 < count && !pbusy[k + 1]) begin
            psize[k] += psize[k + 1];
            drop_entry(k + 1);
          end
          if (k > 0 && !pbusy[k - 1]) begin
            psize[k - 1] += psize[k];
            drop_entry(k);
          end
        end
      end
      grants_q.push_back(g);
    endfunction

    function void check(logic [1:0] st, logic [vpa_pkg::ADDR_W-1:0] bs,
                        logic [vpa_pkg::SIZE_W-1:0] bz);
      grant_t g;
      if (grants_q.size() == 0) begin
        errors++;
        $display("unexpected response: status %0d start %0d size %0d", st, bs, bz);
        return;
      end
      g = grants_q.pop_front();
      if (st !== g.status || bs !== g.bstart || bz !== g.bsize) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp status %0d start %0d size %0d, got %0d %0d %0d",
                   g.status, g.bstart, g.bsize, st, bs, bz);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_wdata = '0;
  vpa_req_if req ();
  vpa_rsp_if rsp ();

  alloc_scoreboard sb = new();
  int  snd_idle = 0;
  int  rcv_idle = 0;
  bit  hold_req = 0;
  int  hold_left = 0;
  int  cycles = 0;

  localparam int CYCLE_LIMIT = 800000;

  variable_partition_allocator_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(req.sink), .rsp(rsp.source)
  );

  always #2 clk = ~clk;

  initial begin
    req.valid = 0;
    req.mode = vpa_pkg::MODE_ALLOC;
    req.owner_id = '0;
    req.request_size = '0;
    rsp.ready = 0;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      rsp.ready = 0;
      hold_left--;
    end else rsp.ready = ($urandom_range(99) >= rcv_idle);
  end

  // response monitor
  always @(posedge clk)
    if (!rst && rsp.valid && rsp.ready) sb.check(rsp.status, rsp.block_start, rsp.block_size);

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[variable_partition_allocator_top] ERROR");
      $finish;
    end
  end

  task automatic send(logic m, logic [vpa_pkg::OWNER_BITS-1:0] own,
                      logic [vpa_pkg::SIZE_W-1:0] rsz);
    while ($urandom_range(99) < snd_idle) begin
      req.valid = 0;
      @(negedge clk);
    end
    req.valid = 1;
    req.mode = m;
    req.owner_id = own;
    req.request_size = rsz;
    do @(posedge clk); while (!req.ready);
    sb.note(m, own, rsz);
    @(negedge clk);
    req.valid = 0;
  endtask

  // wait until every expected response has been seen
  task automatic drain();
    while (sb.grants_q.size() != 0) @(negedge clk);
  endtask

  // drain outstanding responses, let the sequencer settle, then set the policy
  task automatic set_policy(logic [1:0] p);
    drain();
    repeat (40) @(negedge clk);
    cfg_we = 1;
    cfg_wdata = p;
    @(negedge clk);
    cfg_we = 0;
    sb.policy = p;
  endtask

  task automatic random_item();
    logic [vpa_pkg::OWNER_BITS-1:0] own;
    logic [vpa_pkg::SIZE_W-1:0]     rsz;
    int                             r;
    own = ($urandom_range(99) < 80) ? vpa_pkg::OWNER_BITS'($urandom_range(11))
                                     : vpa_pkg::OWNER_BITS'($urandom_range(255));
    r = $urandom_range(99);
    if (r < 70) rsz = vpa_pkg::SIZE_W'($urandom_range(64, 1));
    else if (r < 88) rsz = vpa_pkg::SIZE_W'($urandom_range(400, 65));
    else if (r < 95) rsz = vpa_pkg::SIZE_W'($urandom_range(1024, 1));
    else rsz = vpa_pkg::SIZE_W'($urandom_range(2047, 0));
    send(($urandom_range(99) < 42) ? vpa_pkg::MODE_RELEASE : vpa_pkg::MODE_ALLOC, own, rsz);
  endtask

  initial begin
    logic [1:0] seg_policy[6] = '{vpa_pkg::POL_NEXT, vpa_pkg::POL_BEST, vpa_pkg::POL_WORST,
                                  vpa_pkg::POL_FIRST, vpa_pkg::POL_WORST, vpa_pkg::POL_NEXT};
    repeat (8) @(negedge clk);
    rst = 0;

    // directed: boundary sizes, exact fit, unknown owner, table full, merges
    set_policy(vpa_pkg::POL_FIRST);
    send(vpa_pkg::MODE_ALLOC, 8'd1, 11'd0);
    send(vpa_pkg::MODE_ALLOC, 8'd1, 11'd2047);
    send(vpa_pkg::MODE_ALLOC, 8'd1, 11'd1025);
    send(vpa_pkg::MODE_ALLOC, 8'd255, 11'd1024);
    send(vpa_pkg::MODE_RELEASE, 8'd7, 11'd0);
    send(vpa_pkg::MODE_RELEASE, 8'd255, 11'd2047);
    for (int i = 1; i <= 15; i++) send(vpa_pkg::MODE_ALLOC, i[7:0], 11'd1);
    send(vpa_pkg::MODE_ALLOC, 8'd20, 11'd5);
    send(vpa_pkg::MODE_ALLOC, 8'd0, 11'd1009);
    send(vpa_pkg::MODE_RELEASE, 8'd2, 11'd0);
    send(vpa_pkg::MODE_RELEASE, 8'd1, 11'd0);
    send(vpa_pkg::MODE_RELEASE, 8'd3, 11'd0);

    // random segments across policies and idle profiles
    for (int s = 0; s < 6; s++) begin
      set_policy(seg_policy[s]);
      snd_idle = (s < 2) ? 37 : (s < 4) ? 69 : 0;
      rcv_idle = (s < 2) ? 69 : (s < 4) ? 37 : 0;
      if (s == 4) hold_req = 1;
      for (int n = 0; n < 305; n++) random_item();
    end

    drain();
    repeat (60) @(negedge clk);
    if (sb.errors == 0 && sb.grants_q.size() == 0)
      $display("[variable_partition_allocator_top] OK");
    else
      $display("[variable_partition_allocator_top] ERROR");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/vpa_pkg.sv
rtl/core/vpa_req_if.sv
rtl/core/vpa_cell.sv
rtl/core/vpa_ctrl.sv
rtl/core/variable_partition_allocator_top.sv
tb/sv/tb_variable_partition_allocator_top.sv
